### sv/dsc_pkg.sv
// Shared types, constants and helpers of the display scan controller.
package dsc_pkg;

  localparam int NUM_DIGITS_DEF      = 4;
  localparam int PRESCALE_RELOAD_DEF = 4;

  localparam logic [6:0] BLINK_ON_TICKS  = 7'd65;
  localparam logic [6:0] BLINK_OFF_TICKS = 7'd20;

  localparam logic [7:0]  PAT_BLANK      = 8'hFF;
  localparam logic [7:0]  SEL_HIGH       = 8'hF0;
  localparam logic [7:0]  SEL_NONE       = 8'h00;
  localparam logic [3:0]  LED_ALL_OFF    = 4'hF;
  localparam logic [14:0] TICKER_PERIOD_RST = 15'd1000;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_BLINK   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LED_ON        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LED_BLINK     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DIM_LEVEL     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TICKER_PERIOD = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_EVENT_ENABLE  = 3'd5;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_WRITE = 2'd2
  } action_t;

  typedef struct packed {
    logic [3:0]  digit_blink_mask;
    logic [3:0]  led_on_mask;
    logic [3:0]  led_blink_mask;
    logic [1:0]  dim_level;
    logic [14:0] ticker_period;
    logic        event_enable;
    logic        tick_clear;
  } cfg_t;

  typedef struct packed {
    logic        segment_write;
    logic [7:0]  segment_pattern;
    logic [7:0]  digit_select;
    logic [3:0]  led_pins;
    logic [31:0] countdown;
    logic        tick_event;
  } result_t;

  // Select byte for digit d: high nibble set on the first four digits only.
  function automatic logic [7:0] select_byte(input logic [2:0] d);
    logic [7:0] one_hot;
    one_hot = 8'h01 << d;
    if (d < 3'd4) begin
      return SEL_HIGH | one_hot;
    end
    return one_hot;
  endfunction

endpackage

### sv/dsc_if.sv
// Handshake channels of the display scan controller: input items and result items.
interface dsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] timer_load;
  logic [31:0] display_word;

  modport source (output valid, output action, output timer_load, output display_word,
                  input ready);
  modport sink (input valid, input action, input timer_load, input display_word,
                output ready);
endinterface

interface dsc_out_if;
  logic        valid;
  logic        ready;
  logic        segment_write;
  logic [7:0]  segment_pattern;
  logic [7:0]  digit_select;
  logic [3:0]  led_pins;
  logic [31:0] countdown;
  logic        tick_event;

  modport source (output valid, output segment_write, output segment_pattern,
                  output digit_select, output led_pins, output countdown,
                  output tick_event, input ready);
  modport sink (input valid, input segment_write, input segment_pattern,
                input digit_select, input led_pins, input countdown,
                input tick_event, output ready);
endinterface

### sv/display_scan_controller.sv
// Top level of the display scan controller: multiplexed display scan, LEDs, countdown, ticker.
//
//   channel   direction  content
//   in_ch     sink       action, timer_load, display_word
//   out_ch    source     segment_write, segment_pattern, digit_select, led_pins,
//                        countdown, tick_event
//   cfg_*     write      cfg_we, cfg_index, cfg_wdata
//
// One item a cycle: the result of an accepted item is in the output register the next cycle.
// The single output register sets the figure; in_ch.ready is low only while it holds an
// untaken item.
// Synchronous active-low reset; no clearing pass, the digit patterns reset to blank at once.
module display_scan_controller #(
  parameter int NUM_DIGITS      = dsc_pkg::NUM_DIGITS_DEF,
  parameter int PRESCALE_RELOAD = dsc_pkg::PRESCALE_RELOAD_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  dsc_in_if.sink                          in_ch,
  dsc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [dsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dsc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  dsc_pkg::cfg_t    cfg;
  dsc_pkg::result_t result;
  logic             can_load;
  logic             accept;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  dsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dsc_core #(
    .NUM_DIGITS      (NUM_DIGITS),
    .PRESCALE_RELOAD (PRESCALE_RELOAD)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .accept       (accept),
    .action       (in_ch.action),
    .timer_load   (in_ch.timer_load),
    .display_word (in_ch.display_word),
    .result       (result)
  );

  dsc_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_ch.valid),
    .result   (result),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

### sv/dsc_cfg_regs.sv
// Configuration register bank of the display scan controller.
module dsc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dsc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output dsc_pkg::cfg_t                    cfg
);

  logic [3:0]  digit_blink_r;
  logic [3:0]  led_on_r;
  logic [3:0]  led_blink_r;
  logic [1:0]  dim_level_r;
  logic [14:0] ticker_period_r;
  logic        event_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_blink_r   <= '0;
      led_on_r        <= '0;
      led_blink_r     <= '0;
      dim_level_r     <= '0;
      ticker_period_r <= dsc_pkg::TICKER_PERIOD_RST;
      event_enable_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsc_pkg::REG_DIGIT_BLINK:   digit_blink_r   <= cfg_wdata[3:0];
        dsc_pkg::REG_LED_ON:        led_on_r        <= cfg_wdata[3:0];
        dsc_pkg::REG_LED_BLINK:     led_blink_r     <= cfg_wdata[3:0];
        dsc_pkg::REG_DIM_LEVEL:     dim_level_r     <= cfg_wdata[1:0];
        dsc_pkg::REG_TICKER_PERIOD: ticker_period_r <= cfg_wdata[14:0];
        dsc_pkg::REG_EVENT_ENABLE:  event_enable_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.digit_blink_mask = digit_blink_r;
    cfg.led_on_mask      = led_on_r;
    cfg.led_blink_mask   = led_blink_r;
    cfg.dim_level        = dim_level_r;
    cfg.ticker_period    = ticker_period_r;
    cfg.event_enable     = event_enable_r;
    // A write of the enable register restarts the ticker count.
    cfg.tick_clear       = cfg_we && (cfg_index == dsc_pkg::REG_EVENT_ENABLE);
  end

endmodule

### sv/dsc_core.sv
// Scan, blink, countdown and ticker state with the result logic of one item.
module dsc_core #(
  parameter int NUM_DIGITS      = dsc_pkg::NUM_DIGITS_DEF,
  parameter int PRESCALE_RELOAD = dsc_pkg::PRESCALE_RELOAD_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dsc_pkg::cfg_t    cfg,
  input  logic             accept,
  input  logic [1:0]       action,
  input  logic [31:0]      timer_load,
  input  logic [31:0]      display_word,
  output dsc_pkg::result_t result
);

  localparam int SW = $clog2(NUM_DIGITS);
  localparam int PW = $clog2(PRESCALE_RELOAD + 1);
  localparam int LOADED = (NUM_DIGITS < 4) ? NUM_DIGITS : 4;
  localparam logic [SW-1:0] LAST_DIGIT = SW'(NUM_DIGITS - 1);
  localparam logic [PW-1:0] PS_RELOAD  = PW'(PRESCALE_RELOAD);
  localparam logic [PW-1:0] PS_DIM_MAX = PW'(PRESCALE_RELOAD - 1);

  logic [PW-1:0] prescaler_r,  prescaler_nxt;
  logic [6:0]    blink_cnt_r,  blink_cnt_nxt;
  logic          phase_on_r,   phase_on_nxt;
  logic [SW-1:0] scan_r,       scan_nxt;
  logic [31:0]   countdown_r,  countdown_nxt;
  logic [15:0]   tick_cnt_r,   tick_cnt_nxt;
  logic [3:0]    led_level_r,  led_level_nxt;
  logic [7:0]    patterns_r [NUM_DIGITS];

  logic [PW-1:0] dim;
  logic [PW-1:0] ps_dec;
  logic [6:0]    bc_inc;
  logic [15:0]   tc_inc;
  logic          shown;
  logic          blink_active;
  logic [2:0]    d3;
  logic [SW-1:0] prev_digit;
  logic [3:0]    lit;

  always_comb begin
    prescaler_nxt = prescaler_r;
    blink_cnt_nxt = blink_cnt_r;
    phase_on_nxt  = phase_on_r;
    scan_nxt      = scan_r;
    countdown_nxt = countdown_r;
    tick_cnt_nxt  = tick_cnt_r;
    led_level_nxt = led_level_r;

    dim    = (PW'(cfg.dim_level) >= PS_RELOAD) ? PS_DIM_MAX : PW'(cfg.dim_level);
    ps_dec = prescaler_r - PW'(1);
    bc_inc = blink_cnt_r + 7'd1;
    tc_inc = tick_cnt_r + 16'd1;
    d3     = 3'(scan_r);
    prev_digit   = (scan_r == '0) ? LAST_DIGIT : scan_r - SW'(1);
    blink_active = (cfg.digit_blink_mask != '0) || (cfg.led_blink_mask != '0);
    shown  = 1'b1;
    lit    = '0;

    result.segment_write   = 1'b0;
    result.segment_pattern = dsc_pkg::PAT_BLANK;
    result.digit_select    = dsc_pkg::SEL_NONE;
    result.tick_event      = 1'b0;

    unique case (action)
      dsc_pkg::ACT_LOAD: countdown_nxt = timer_load;
      dsc_pkg::ACT_TICK: begin
        prescaler_nxt = ps_dec;
        if (ps_dec == '0) begin
          prescaler_nxt = PS_RELOAD;
          if (blink_active) begin
            blink_cnt_nxt = bc_inc;
            if (phase_on_r) begin
              if (bc_inc > dsc_pkg::BLINK_ON_TICKS) begin
                phase_on_nxt  = 1'b0;
                blink_cnt_nxt = '0;
                shown         = 1'b0;
              end
            end else begin
              shown = 1'b0;
              if (bc_inc > dsc_pkg::BLINK_OFF_TICKS) begin
                phase_on_nxt  = 1'b1;
                blink_cnt_nxt = '0;
                shown         = 1'b1;
              end
            end
          end
          result.segment_write   = 1'b1;
          result.digit_select    = dsc_pkg::select_byte(d3);
          result.segment_pattern = patterns_r[scan_r];
          // Blank a blinking digit in the off half; digits past the fourth never blink.
          if ((d3 < 3'd4) && cfg.digit_blink_mask[d3[1:0]] && !shown) begin
            result.segment_pattern = dsc_pkg::PAT_BLANK;
          end
          scan_nxt = (scan_r == LAST_DIGIT) ? '0 : scan_r + SW'(1);
          lit = (cfg.led_on_mask & {4{shown}} & cfg.led_blink_mask)
              | (cfg.led_on_mask & ~cfg.led_blink_mask);
          led_level_nxt = ~lit;
        end else if (ps_dec == dim) begin
          // Dim: blank the digit driven last
          result.segment_write = 1'b1;
          result.digit_select  = dsc_pkg::select_byte(3'(prev_digit));
        end
        if (countdown_r != '0) begin
          countdown_nxt = countdown_r - 32'd1;
        end
        tick_cnt_nxt = tc_inc;
        if (tc_inc > 16'(cfg.ticker_period)) begin
          tick_cnt_nxt      = '0;
          result.tick_event = cfg.event_enable;
        end
      end
      default: ;
    endcase

    result.led_pins  = led_level_nxt;
    result.countdown = countdown_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescaler_r <= PS_RELOAD;
      blink_cnt_r <= '0;
      phase_on_r  <= 1'b0;
      scan_r      <= '0;
      countdown_r <= '0;
      tick_cnt_r  <= '0;
      led_level_r <= dsc_pkg::LED_ALL_OFF;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        patterns_r[i] <= dsc_pkg::PAT_BLANK;
      end
    end else begin
      if (accept) begin
        prescaler_r <= prescaler_nxt;
        blink_cnt_r <= blink_cnt_nxt;
        phase_on_r  <= phase_on_nxt;
        scan_r      <= scan_nxt;
        countdown_r <= countdown_nxt;
        led_level_r <= led_level_nxt;
        if (action == dsc_pkg::ACT_WRITE) begin
          for (int i = 0; i < LOADED; i++) begin
            patterns_r[i] <= display_word[8*i +: 8];
          end
        end
      end
      if (cfg.tick_clear) begin
        tick_cnt_r <= '0;
      end else if (accept) begin
        tick_cnt_r <= tick_cnt_nxt;
      end
    end
  end

endmodule

### sv/dsc_out_reg.sv
// Result register of the display scan controller, driving the result channel.
module dsc_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  dsc_pkg::result_t result,
  output logic             can_load,
  dsc_out_if.source        out_ch
);

  logic             valid_r;
  dsc_pkg::result_t data_r;

  // Take a new item whenever the held one is gone or leaves this cycle.
  assign can_load = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      data_r <= result;
    end
  end

  assign out_ch.valid           = valid_r;
  assign out_ch.segment_write   = data_r.segment_write;
  assign out_ch.segment_pattern = data_r.segment_pattern;
  assign out_ch.digit_select    = data_r.digit_select;
  assign out_ch.led_pins        = data_r.led_pins;
  assign out_ch.countdown       = data_r.countdown;
  assign out_ch.tick_event      = data_r.tick_event;

endmodule
